/* sv/phm61_pkg.sv */
package phm61_pkg;

    localparam int unsigned HASH_W = 61;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned HALF_W = 32;

    localparam logic [HASH_W-1:0] MOD_P      = {HASH_W{1'b1}};
    localparam logic [HASH_W-1:0] BASE_RESET = HASH_W'(1000003);
    localparam logic [HASH_W-1:0] ACC_ZERO   = '0;
    localparam logic [HASH_W-1:0] POW_ONE    = HASH_W'(1);

    typedef logic [HASH_W-1:0] t_hash;
    typedef logic [BYTE_W-1:0] t_byte;

    typedef struct packed {
        t_hash forward_acc;
        t_hash reverse_acc;
        t_hash power_of_base;
    } t_state;

    typedef struct packed {
        t_hash forward_hash;
        t_hash reverse_hash;
        logic  string_done;
    } t_result;

    // a + b mod P for a, b already reduced
    function automatic t_hash add_mod(input t_hash a, input t_hash b);
        logic [HASH_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= {1'b0, MOD_P}) begin
            sum = sum - {1'b0, MOD_P};
        end
        return sum[HASH_W-1:0];
    endfunction

    // byte * p mod P, where p is already reduced
    function automatic t_hash mul_byte_mod(input t_byte b, input t_hash p);
        logic [HASH_W+BYTE_W-1:0] prod;
        logic [HASH_W:0]          fold;
        prod = (HASH_W+BYTE_W)'(b) * (HASH_W+BYTE_W)'(p);
        fold = {1'b0, prod[HASH_W-1:0]} + (HASH_W+1)'(prod[HASH_W+BYTE_W-1:HASH_W]);
        if (fold >= {1'b0, MOD_P}) begin
            fold = fold - {1'b0, MOD_P};
        end
        return fold[HASH_W-1:0];
    endfunction

endpackage

/* sv/phm61_stream_if.sv */
interface phm61_in_if;
    logic              valid;
    logic              ready;
    phm61_pkg::t_byte  data_byte;
    logic              is_last;

    modport source (output valid, output data_byte, output is_last, input ready);
    modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

interface phm61_out_if;
    logic              valid;
    logic              ready;
    phm61_pkg::t_hash  forward_hash;
    phm61_pkg::t_hash  reverse_hash;
    logic              string_done;

    modport source (output valid, output forward_hash, output reverse_hash,
                    output string_done, input ready);
    modport sink   (input valid, input forward_hash, input reverse_hash,
                    input string_done, output ready);
endinterface

/* sv/phm61_mulmod.sv */
module phm61_mulmod (
    input  phm61_pkg::t_hash i_x,
    input  phm61_pkg::t_hash i_y,
    output phm61_pkg::t_hash o_z
);
    import phm61_pkg::*;

    localparam int unsigned PROD_W = 2 * HASH_W;
    localparam int unsigned HI_W   = HASH_W - HALF_W;

    logic [HALF_W-1:0]      w_xl, w_yl;
    logic [HI_W-1:0]        w_xh, w_yh;
    logic [2*HALF_W-1:0]    w_ll;
    logic [HASH_W-1:0]      w_lh, w_hl;
    logic [2*HI_W-1:0]      w_hh;
    logic [HASH_W:0]        w_mid;
    logic [PROD_W-1:0]      w_prod;
    logic [HASH_W:0]        w_s1;
    logic [HASH_W-1:0]      w_s2;

    assign w_xl = i_x[HALF_W-1:0];
    assign w_xh = i_x[HASH_W-1:HALF_W];
    assign w_yl = i_y[HALF_W-1:0];
    assign w_yh = i_y[HASH_W-1:HALF_W];

    // four partial products, each at most 32x32
    assign w_ll = (2*HALF_W)'(w_xl) * (2*HALF_W)'(w_yl);
    assign w_lh = HASH_W'(w_xl) * HASH_W'(w_yh);
    assign w_hl = HASH_W'(w_xh) * HASH_W'(w_yl);
    assign w_hh = (2*HI_W)'(w_xh) * (2*HI_W)'(w_yh);

    assign w_mid  = {1'b0, w_lh} + {1'b0, w_hl};
    assign w_prod = PROD_W'(w_ll)
                  + {(PROD_W-HASH_W-1-HALF_W)'(0), w_mid, HALF_W'(0)}
                  + {w_hh, (2*HALF_W)'(0)};

    // 2^61 is 1 mod P: add the high half onto the low half, twice
    assign w_s1 = {1'b0, w_prod[HASH_W-1:0]} + {1'b0, w_prod[PROD_W-1:HASH_W]};
    assign w_s2 = w_s1[HASH_W-1:0] + HASH_W'(w_s1[HASH_W]);
    assign o_z  = (w_s2 == MOD_P) ? ACC_ZERO : w_s2;
endmodule

/* sv/phm61_step.sv */
module phm61_step (
    input  phm61_pkg::t_state  i_state,
    input  phm61_pkg::t_hash   i_base,
    input  phm61_pkg::t_byte   i_data_byte,
    input  logic               i_is_last,
    output phm61_pkg::t_state  o_state,
    output phm61_pkg::t_result o_result
);
    import phm61_pkg::*;

    t_hash w_fwd_prod;
    t_hash w_pow_next;
    t_hash w_fwd;
    t_hash w_rev;

    phm61_mulmod u_mul_fwd (
        .i_x (i_state.forward_acc),
        .i_y (i_base),
        .o_z (w_fwd_prod)
    );

    phm61_mulmod u_mul_pow (
        .i_x (i_state.power_of_base),
        .i_y (i_base),
        .o_z (w_pow_next)
    );

    assign w_fwd = add_mod(w_fwd_prod, HASH_W'(i_data_byte));
    assign w_rev = add_mod(i_state.reverse_acc,
                           mul_byte_mod(i_data_byte, i_state.power_of_base));

    assign o_result.forward_hash = w_fwd;
    assign o_result.reverse_hash = w_rev;
    assign o_result.string_done  = i_is_last;

    always_comb begin
        if (i_is_last) begin
            o_state.forward_acc   = ACC_ZERO;
            o_state.reverse_acc   = ACC_ZERO;
            o_state.power_of_base = POW_ONE;
        end else begin
            o_state.forward_acc   = w_fwd;
            o_state.reverse_acc   = w_rev;
            o_state.power_of_base = w_pow_next;
        end
    end
endmodule

/* sv/poly_hash_mersenne61.sv */
// a byte accepted into the input register is stepped into the result register once the result side has room
// throughput: one byte per cycle, sustained while the result side keeps taking
// the rate is set by the modular multiply-fold feeding the forward accumulator back each cycle
// reset (i_rst_n, synchronous, active low): pipeline empties, accumulators clear,
// running power goes to one and the base register returns to 1000003
module poly_hash_mersenne61 (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  phm61_pkg::t_hash     i_cfg_wr_data,
    phm61_in_if.sink             i_byte,
    phm61_out_if.source          o_hash
);
    import phm61_pkg::*;

    t_hash   r_base;
    t_state  r_state;
    t_state  n_state;
    logic    r_in_valid;
    t_byte   r_in_byte;
    logic    r_in_last;
    logic    r_out_valid;
    t_result r_out;
    t_result n_out;
    logic    w_advance;

    assign w_advance    = r_in_valid && (!r_out_valid || o_hash.ready);
    assign i_byte.ready = !r_in_valid || w_advance;

    phm61_step u_step (
        .i_state     (r_state),
        .i_base      (r_base),
        .i_data_byte (r_in_byte),
        .i_is_last   (r_in_last),
        .o_state     (n_state),
        .o_result    (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_RESET;
        end else if (i_cfg_wr_en) begin
            r_base <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid            <= 1'b0;
            r_out_valid           <= 1'b0;
            r_state.forward_acc   <= ACC_ZERO;
            r_state.reverse_acc   <= ACC_ZERO;
            r_state.power_of_base <= POW_ONE;
        end else begin
            if (i_byte.ready) begin
                r_in_valid <= i_byte.valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (o_hash.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte <= i_byte.data_byte;
            r_in_last <= i_byte.is_last;
        end
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    assign o_hash.valid        = r_out_valid;
    assign o_hash.forward_hash = r_out.forward_hash;
    assign o_hash.reverse_hash = r_out.reverse_hash;
    assign o_hash.string_done  = r_out.string_done;

    a_string_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && r_in_last |=> r_state.forward_acc == ACC_ZERO
            && r_state.reverse_acc == ACC_ZERO && r_state.power_of_base == POW_ONE)
        else $error("state not restored after end of string");

    a_advance_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("result register empty after a step");

    a_hash_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.forward_hash != MOD_P && r_out.reverse_hash != MOD_P
            && r_state.forward_acc != MOD_P && r_state.reverse_acc != MOD_P)
        else $error("hash value not reduced below modulus");

    a_no_advance_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_hash.ready |-> !w_advance)
        else $error("pipeline advanced into a stalled result");
endmodule

/* dv/tb_poly_hash_mersenne61.sv */
`timescale 1ns / 1ps

import phm61_pkg::*;

class hash_scoreboard;
    t_hash   base;
    t_hash   fwd_acc;
    t_hash   rev_acc;
    t_hash   pow_acc;
    t_result pending_hashes[$];
    int      errors;

    function new();
        errors = 0;
        restore_reset();
    endfunction

    function void restore_reset();
        base     = BASE_RESET;
        fwd_acc  = ACC_ZERO;
        rev_acc  = ACC_ZERO;
        pow_acc  = POW_ONE;
        pending_hashes.delete();
    endfunction

    // plain wide product, then reduce; a base of all ones behaves as zero here
    function t_hash mul_p(input t_hash a, input t_hash b);
        logic [2*HASH_W-1:0] prod;
        prod = (2*HASH_W)'(a) * (2*HASH_W)'(b);
        return t_hash'(prod % (2*HASH_W)'(MOD_P));
    endfunction

    function t_hash add_p(input t_hash a, input t_hash b);
        logic [HASH_W:0] total;
        total = (HASH_W+1)'(a) + (HASH_W+1)'(b);
        return t_hash'(total % (HASH_W+1)'(MOD_P));
    endfunction

    function void absorb_byte(input t_byte b, input logic last);
        t_result r;
        fwd_acc  = add_p(mul_p(fwd_acc, base), t_hash'(b));
        rev_acc  = add_p(rev_acc, mul_p(t_hash'(b), pow_acc));
        pow_acc  = mul_p(pow_acc, base);
        r.forward_hash = fwd_acc;
        r.reverse_hash = rev_acc;
        r.string_done  = last;
        pending_hashes.push_back(r);
        if (last) begin
            fwd_acc  = ACC_ZERO;
            rev_acc  = ACC_ZERO;
            pow_acc  = POW_ONE;
        end
    endfunction

    function void check_hash(input t_result got);
        t_result want;
        if (pending_hashes.size() == 0) begin
            $error("hash result with no byte pending: forward_hash %h reverse_hash %h",
                   got.forward_hash, got.reverse_hash);
            errors++;
            return;
        end
        want = pending_hashes.pop_front();
        if (got.forward_hash !== want.forward_hash) begin
            $error("forward_hash: expected %h, actual %h", want.forward_hash, got.forward_hash);
            errors++;
        end
        if (got.reverse_hash !== want.reverse_hash) begin
            $error("reverse_hash: expected %h, actual %h", want.reverse_hash, got.reverse_hash);
            errors++;
        end
        if (got.string_done !== want.string_done) begin
            $error("string_done: expected %b, actual %b", want.string_done, got.string_done);
            errors++;
        end
    endfunction
endclass

module tb_poly_hash_mersenne61;

    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 5000;
    localparam int RANDOM_BYTES = 1400;
    localparam int DRAIN_CYCLES = 4;

    logic  i_clk;
    logic  i_rst_n;
    logic  cfg_wr_en;
    t_hash cfg_wr_data;
    bit    no_idle;
    bit    hold_req;

    hash_scoreboard sb;

    phm61_in_if  byte_if();
    phm61_out_if hash_if();

    poly_hash_mersenne61 uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_byte        (byte_if),
        .o_hash        (hash_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic send_byte(input t_byte b, input logic last);
        while (!no_idle && $urandom_range(99) < 26) begin
            byte_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_if.valid     <= 1'b1;
        byte_if.data_byte <= b;
        byte_if.is_last   <= last;
        @(posedge i_clk);
        while (!byte_if.ready) @(posedge i_clk);
        sb.absorb_byte(b, last);
    endtask

    // stop offering and let every expected hash come back
    task automatic wait_idle();
        byte_if.valid <= 1'b0;
        while (sb.pending_hashes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_base(input t_hash v);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        sb.base = v;
    endtask

    function automatic t_byte pick_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return t_byte'($urandom);
        endcase
    endfunction

    function automatic t_hash pick_base();
        case ($urandom_range(9))
            0:       return ACC_ZERO;
            1:       return POW_ONE;
            2:       return MOD_P - 1;
            3:       return MOD_P;
            4:       return BASE_RESET;
            5:       return t_hash'($urandom_range(2, 300));
            default: return t_hash'({$urandom, $urandom});
        endcase
    endfunction

    initial begin : stimulus
        int sent;
        int phase;
        int count;
        int len;
        int goal;

        i_rst_n           = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = '0;
        byte_if.valid     = 1'b0;
        byte_if.data_byte = '0;
        byte_if.is_last   = 1'b0;
        no_idle           = 1'b0;
        hold_req          = 1'b0;
        sb = new();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset base, byte extremes
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h01, 1'b1);
        send_byte(8'hFF, 1'b1);
        // largest legal base
        write_base(MOD_P - 1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        // zero base: forward hash is just the last byte
        write_base(ACC_ZERO);
        send_byte(8'h07, 1'b0);
        send_byte(8'hC8, 1'b1);
        // base equal to the modulus acts as zero
        write_base(MOD_P);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b1);
        // base change in the middle of a string
        write_base(POW_ONE);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        write_base(t_hash'({$urandom, $urandom}));
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_BYTES) begin
            if (phase < 2 || $urandom_range(3) != 0) begin
                write_base(pick_base());
            end
            no_idle = (phase == 3);
            if (phase == 5 || phase == 12) begin
                hold_req = 1'b1;
            end
            goal  = $urandom_range(60, 150);
            count = 0;
            while (count < goal) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 10);
                for (int k = 0; k < len; k++) begin
                    send_byte(pick_byte(), k == len - 1);
                end
                count += len;
            end
            // leave a string open so the next base lands mid-string
            if ($urandom_range(2) == 0) begin
                len = $urandom_range(1, 5);
                repeat (len) send_byte(pick_byte(), 1'b0);
                count += len;
            end
            no_idle = 1'b0;
            sent += count;
            phase++;
        end

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_hashes.size() == 0) begin
            $display("poly_hash_mersenne61 test passed");
        end else begin
            $display("poly_hash_mersenne61 test failed");
        end
        $finish;
    end

    initial begin : result_side
        int      hold_left;
        t_result got;

        hold_left     = 0;
        hash_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hash_if.ready <= 1'b0;
                hold_left--;
            end else if (!no_idle && $urandom_range(99) < 26) begin
                hash_if.ready <= 1'b0;
            end else begin
                hash_if.ready <= 1'b1;
            end
            @(posedge i_clk);
            if (hash_if.valid && hash_if.ready) begin
                got.forward_hash = hash_if.forward_hash;
                got.reverse_hash = hash_if.reverse_hash;
                got.string_done  = hash_if.string_done;
                sb.check_hash(got);
            end
        end
    end

    initial begin : watchdog
        int quiet;

        quiet = 0;
        wait (i_rst_n === 1'b1);
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((byte_if.valid && byte_if.ready) || (hash_if.valid && hash_if.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("poly_hash_mersenne61 test failed");
        $finish;
    end

endmodule

/* sim.f */
sv/phm61_pkg.sv
sv/phm61_stream_if.sv
sv/phm61_mulmod.sv
sv/phm61_step.sv
sv/poly_hash_mersenne61.sv
dv/tb_poly_hash_mersenne61.sv
